// File: rtl/bsfr_pkg.sv
`timescale 1ns / 1ps
package bsfr_pkg;

   localparam logic [7:0] CODE_START    = 8'h80;
   localparam logic [7:0] CODE_END      = 8'h81;
   localparam logic [7:0] CODE_ESC      = 8'h1B;
   localparam logic [7:0] ESC_FOR_START = 8'hE7;
   localparam logic [7:0] ESC_FOR_END   = 8'hE8;
   localparam logic [7:0] ESC_FOR_ESC   = 8'h00;
   localparam logic [7:0] SUM_MASK      = 8'h7F;

   localparam logic [1:0] MODE_HUNT = 2'd0;
   localparam logic [1:0] MODE_DATA = 2'd1;
   localparam logic [1:0] MODE_ESC  = 2'd2;

   localparam logic [2:0] ST_GOOD  = 3'd0;
   localparam logic [2:0] ST_SUM   = 3'd1;
   localparam logic [2:0] ST_ESC   = 3'd2;
   localparam logic [2:0] ST_ABORT = 3'd3;
   localparam logic [2:0] ST_EMPTY = 3'd4;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] held_byte;
      logic       held_valid;
      logic [7:0] running_xor;
   } frame_state_type;

   typedef struct packed {
      logic       present;
      logic [7:0] out_byte;
      logic       frame_end;
      logic [2:0] status;
   } result_type;

   localparam frame_state_type STATE_RESET = '{
      mode: MODE_HUNT, held_byte: 8'h00, held_valid: 1'b0, running_xor: 8'h00};

endpackage

// File: rtl/bsfr_step.sv
`timescale 1ns / 1ps
module bsfr_step (
   input  bsfr_pkg::frame_state_type cur_state,
   input  logic [7:0]                in_byte,
   output bsfr_pkg::frame_state_type nxt_state,
   output bsfr_pkg::result_type      result
);
   import bsfr_pkg::*;

   logic       push_en;
   logic [7:0] push_val;
   logic       end_en;
   logic [2:0] end_status;
   frame_state_type base;

   always_comb begin
      base       = cur_state;
      push_en    = 1'b0;
      push_val   = in_byte;
      end_en     = 1'b0;
      end_status = ST_GOOD;
      case (cur_state.mode)
         MODE_DATA: begin
            if (in_byte == CODE_END) begin
               end_en = 1'b1;
               if (!cur_state.held_valid) begin
                  end_status = ST_EMPTY;
               end else if (cur_state.held_byte == (cur_state.running_xor & SUM_MASK)) begin
                  end_status = ST_GOOD;
               end else begin
                  end_status = ST_SUM;
               end
               base = STATE_RESET;
            end else if (in_byte == CODE_START) begin
               end_en     = 1'b1;
               end_status = ST_ABORT;
               base       = STATE_RESET;
               base.mode  = MODE_DATA;
            end else if (in_byte == CODE_ESC) begin
               base.mode = MODE_ESC;
            end else begin
               push_en = 1'b1;
            end
         end
         MODE_ESC: begin
            base.mode = MODE_DATA;
            if (in_byte == CODE_START) begin
               end_en     = 1'b1;
               end_status = ST_ABORT;
               base       = STATE_RESET;
               base.mode  = MODE_DATA;
            end else if (in_byte == ESC_FOR_START) begin
               push_en  = 1'b1;
               push_val = CODE_START;
            end else if (in_byte == ESC_FOR_END) begin
               push_en  = 1'b1;
               push_val = CODE_END;
            end else if (in_byte == ESC_FOR_ESC) begin
               push_en  = 1'b1;
               push_val = CODE_ESC;
            end else begin
               end_en     = 1'b1;
               end_status = ST_ESC;
               base       = STATE_RESET;
            end
         end
         default: begin
            if (in_byte == CODE_START) begin
               base      = STATE_RESET;
               base.mode = MODE_DATA;
            end else begin
               base.mode = MODE_HUNT;
            end
         end
      endcase

      nxt_state        = base;
      result.present   = end_en;
      result.out_byte  = 8'h00;
      result.frame_end = end_en;
      result.status    = end_status;
      if (push_en) begin
         // release the held byte, hold the new one
         result.present   = cur_state.held_valid;
         result.out_byte  = cur_state.held_byte;
         result.frame_end = 1'b0;
         result.status    = ST_GOOD;
         if (cur_state.held_valid) begin
            nxt_state.running_xor = cur_state.running_xor ^ cur_state.held_byte;
         end
         nxt_state.held_byte  = push_val;
         nxt_state.held_valid = 1'b1;
      end
   end

endmodule

// File: rtl/byte_stuffed_frame_receiver.sv
`timescale 1ns / 1ps
// byte-stuffed frame receiver
// req channel: one raw link byte per beat on req_in_byte, taken when
//   req_valid is high and req_stall is low
// rsp channel: unstuffed payload bytes with rsp_frame_end low, then one
//   end beat per frame with rsp_frame_end high and the frame status
//   (good, checksum error, bad escape, aborted by start, empty)
// a byte first lands in an input register, is decoded against the frame
//   state while it is held there; its result, if any, sits in the rsp
//   register
// throughput: one byte per cycle while req_stall is low, set by the single
//   decode stage that updates the frame state as each byte advances
// payload bytes leave one byte late, so the checksum byte never leaves
// reset clears both registers and returns to hunting for a start code
// when rsp_stall holds, the rsp beat stays put; the input register still
//   drains bytes that make no result, and req_stall rises only when a
//   byte with a result waits behind the stalled beat
module byte_stuffed_frame_receiver (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_frame_end,
   output logic [2:0] rsp_status
);
   import bsfr_pkg::*;

   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   frame_state_type state_ff;
   frame_state_type state_in;
   result_type      step_res;
   logic            rsp_valid_ff;
   logic [7:0]      rsp_byte_ff;
   logic            rsp_end_ff;
   logic [2:0]      rsp_status_ff;
   logic            out_free;
   logic            advance;
   logic            req_take;

   bsfr_step u_step (
      .cur_state (state_ff),
      .in_byte   (in_byte_ff),
      .nxt_state (state_in),
      .result    (step_res)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (out_free || !step_res.present);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
            in_byte_ff  <= req_in_byte;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            state_ff <= state_in;
         end
         if (advance && step_res.present) begin
            rsp_valid_ff  <= 1'b1;
            rsp_byte_ff   <= step_res.out_byte;
            rsp_end_ff    <= step_res.frame_end;
            rsp_status_ff <= step_res.status;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_frame_end = rsp_end_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

// File: tb/tb_byte_stuffed_frame_receiver.sv
`timescale 1ns / 1ps
module tb_byte_stuffed_frame_receiver;
   import bsfr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LINK_BYTES  = 1500;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      logic [2:0] status;
   } rsp_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_frame_end;
   logic [2:0] rsp_status;

   logic [7:0]   link_bytes[$];
   rsp_beat_type expected_rsp[$];
   int           errors = 0;
   int           cycles = 0;
   int           send_gap = 0;
   int           stall_left = 0;
   bit           send_calm = 1'b0;
   bit           recv_calm = 1'b0;

   // decoder state mirror
   logic [1:0] dec_mode = MODE_HUNT;
   logic [7:0] pend_byte = 8'h00;
   logic       pend_valid = 1'b0;
   logic [7:0] frame_xor = 8'h00;

   byte_stuffed_frame_receiver u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_frame_end (rsp_frame_end),
      .rsp_status    (rsp_status)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic int idle_len(input bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(13, 40);
   endfunction

   task automatic restart_decoder(input logic [1:0] m);
      dec_mode   = m;
      pend_byte  = 8'h00;
      pend_valid = 1'b0;
      frame_xor  = 8'h00;
   endtask

   task automatic expect_end(input logic [2:0] st);
      expected_rsp.push_back('{out_byte: 8'h00, frame_end: 1'b1, status: st});
   endtask

   task automatic hold_byte(input logic [7:0] b);
      if (pend_valid) begin
         expected_rsp.push_back('{out_byte: pend_byte, frame_end: 1'b0, status: ST_GOOD});
         frame_xor = frame_xor ^ pend_byte;
      end
      pend_byte  = b;
      pend_valid = 1'b1;
   endtask

   task automatic decode_link_byte(input logic [7:0] b);
      case (dec_mode)
         MODE_DATA: begin
            if (b == CODE_END) begin
               if (!pend_valid) expect_end(ST_EMPTY);
               else if (pend_byte == (frame_xor & SUM_MASK)) expect_end(ST_GOOD);
               else expect_end(ST_SUM);
               restart_decoder(MODE_HUNT);
            end else if (b == CODE_START) begin
               restart_decoder(MODE_DATA);
               expect_end(ST_ABORT);
            end else if (b == CODE_ESC) begin
               dec_mode = MODE_ESC;
            end else begin
               hold_byte(b);
            end
         end
         MODE_ESC: begin
            if (b == CODE_START) begin
               restart_decoder(MODE_DATA);
               expect_end(ST_ABORT);
            end else begin
               dec_mode = MODE_DATA;
               case (b)
                  ESC_FOR_START: hold_byte(CODE_START);
                  ESC_FOR_END:   hold_byte(CODE_END);
                  ESC_FOR_ESC:   hold_byte(CODE_ESC);
                  default: begin
                     restart_decoder(MODE_HUNT);
                     expect_end(ST_ESC);
                  end
               endcase
            end
         end
         default: begin
            if (b == CODE_START) restart_decoder(MODE_DATA);
            else dec_mode = MODE_HUNT;
         end
      endcase
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_in_byte <= 8'h00;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) decode_link_byte(req_in_byte);
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
               req_valid <= 1'b0;
            end else if (link_bytes.size() > 0) begin
               req_in_byte <= link_bytes.pop_front();
               req_valid   <= 1'b1;
               if ($urandom_range(0, 199) == 0) send_calm = !send_calm;
               send_gap = idle_len(send_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_beat_type exp_beat;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $error("rsp beat with nothing expected: out_byte %0h frame_end %0b status %0d",
                      rsp_out_byte, rsp_frame_end, rsp_status);
               errors++;
            end else begin
               exp_beat = expected_rsp.pop_front();
               if (rsp_out_byte !== exp_beat.out_byte) begin
                  $error("out_byte: expected %0h, got %0h", exp_beat.out_byte, rsp_out_byte);
                  errors++;
               end
               if (rsp_frame_end !== exp_beat.frame_end) begin
                  $error("frame_end: expected %0b, got %0b", exp_beat.frame_end,
                         rsp_frame_end);
                  errors++;
               end
               if (rsp_status !== exp_beat.status) begin
                  $error("status: expected %0d, got %0d", exp_beat.status, rsp_status);
                  errors++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 199) == 0) recv_calm = !recv_calm;
            stall_left = idle_len(recv_calm);
         end
      end
   end

   task automatic push_raw(input logic [7:0] b);
      link_bytes.push_back(b);
   endtask

   task automatic push_stuffed(input logic [7:0] b);
      if (b == CODE_START) begin
         push_raw(CODE_ESC);
         push_raw(ESC_FOR_START);
      end else if (b == CODE_END) begin
         push_raw(CODE_ESC);
         push_raw(ESC_FOR_END);
      end else if (b == CODE_ESC) begin
         push_raw(CODE_ESC);
         push_raw(ESC_FOR_ESC);
      end else begin
         push_raw(b);
      end
   endtask

   function automatic logic [7:0] pick_payload();
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 2))
            0: return CODE_START;
            1: return CODE_END;
            default: return CODE_ESC;
         endcase
      end
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic int pick_length();
      if ($urandom_range(0, 9) != 0) return $urandom_range(0, 10);
      return $urandom_range(11, 60);
   endfunction

   // payload, checksum and end code; the start code is pushed by the caller
   task automatic push_frame_body(input int n, input logic [7:0] sum_flip);
      logic [7:0] x;
      logic [7:0] b;
      x = 8'h00;
      for (int i = 0; i < n; i++) begin
         b = pick_payload();
         x = x ^ b;
         push_stuffed(b);
      end
      push_stuffed((x & SUM_MASK) ^ sum_flip);
      push_raw(CODE_END);
   endtask

   task automatic push_random_frame();
      int         kind;
      logic [7:0] b;
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
         push_raw(CODE_START);
         push_frame_body(pick_length(), 8'h00);
      end else if (kind < 75) begin
         push_raw(CODE_START);
         push_frame_body(pick_length(), 8'($urandom_range(1, 255)));
      end else if (kind < 81) begin
         push_raw(CODE_START);
         repeat ($urandom_range(0, 6)) push_stuffed(pick_payload());
         push_raw(CODE_ESC);
         b = 8'($urandom_range(0, 255));
         if (b == ESC_FOR_START || b == ESC_FOR_END || b == ESC_FOR_ESC || b == CODE_START)
            b = CODE_END;
         push_raw(b);
      end else if (kind < 87) begin
         push_raw(CODE_START);
         repeat ($urandom_range(0, 6)) push_stuffed(pick_payload());
         if ($urandom_range(0, 1)) push_raw(CODE_ESC);
         push_raw(CODE_START);
         push_frame_body(pick_length(), 8'h00);
      end else if (kind < 91) begin
         push_raw(CODE_START);
         push_raw(CODE_END);
      end else begin
         repeat ($urandom_range(1, 8)) push_raw(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      // hunting noise, empty frame, checksum-only frame, checksum with top bit
      push_raw(8'hFF);
      push_raw(CODE_START); push_raw(CODE_END);
      push_raw(CODE_START); push_raw(8'h00); push_raw(CODE_END);
      push_raw(CODE_START); push_raw(8'h85); push_raw(CODE_END);
      // all three escapes, then checksum 0x1a
      push_raw(CODE_START);
      push_raw(CODE_ESC); push_raw(ESC_FOR_START);
      push_raw(CODE_ESC); push_raw(ESC_FOR_END);
      push_raw(CODE_ESC); push_raw(ESC_FOR_ESC);
      push_raw(8'h1A); push_raw(CODE_END);
      // bad escape on the end code
      push_raw(CODE_START); push_raw(8'h41); push_raw(CODE_ESC); push_raw(CODE_END);
      // start right after escape, then the reopened frame ends empty
      push_raw(CODE_START); push_raw(8'h12); push_raw(CODE_ESC); push_raw(CODE_START);
      push_raw(CODE_END);
      while (link_bytes.size() < LINK_BYTES) push_random_frame();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (link_bytes.size() != 0 || req_valid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
